FILE: design/assert_macros.svh
// Assertion macros used by pwm_frequency_retune.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a boolean at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/pfr_pkg.sv
// Widths and constants of the PWM frequency retune block.
package pfr_pkg;

  localparam int CLOCK_W   = 27;
  localparam int FREQ_W    = 32;
  localparam int CHAN_W    = 3;
  localparam int MATCH_W   = 16;
  localparam int PERIOD_W  = 16;
  localparam int PRESC_W   = 3;

  localparam logic [CLOCK_W-1:0]  CLOCK_HZ_RESET = CLOCK_W'(20971520);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 16'hFFFF;
  localparam logic [PRESC_W-1:0]  PRESCALE_MAX   = 3'b111;

  // Shared divider: 32-bit dividend, 32-bit divisor, one quotient bit a step
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

FILE: design/pwm_frequency_retune.sv
// PWM frequency retune: one shared restoring divider under a small sequencer.
// A request with a nonzero frequency and a nonzero stored period runs from
// acceptance through the period division clock_hz / wanted_freq, prescale
// normalization (one halving per cycle), a multiply step, the match rescale
// division and a step to post the result; the idle state then takes the
// next request. Both divisions run one quotient bit per cycle on the same
// subtractor. A rejected request (zero frequency or zero stored period) goes
// straight to the final step. in_stall stays high while a request is in work;
// a finished result sits in the output register, so a new request is taken
// while it waits. Further stall of the output while the next result is ready
// holds the sequencer in its final step. The user must write cfg_clock_hz
// only while idle; the block itself does not enforce it.
`include "assert_macros.svh"

module pwm_frequency_retune (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [pfr_pkg::CLOCK_W-1:0]   cfg_clock_hz,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfr_pkg::FREQ_W-1:0]    in_wanted_freq,
  input  logic [pfr_pkg::CHAN_W-1:0]    in_target_channel,
  input  logic [pfr_pkg::MATCH_W-1:0]   in_current_match,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfr_pkg::PERIOD_W-1:0]  out_new_period,
  output logic [pfr_pkg::PRESC_W-1:0]   out_new_prescale,
  output logic [pfr_pkg::MATCH_W-1:0]   out_new_match,
  output logic [pfr_pkg::CHAN_W-1:0]    out_match_channel,
  output logic                          out_error_flag
);
  import pfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_NORM,
    ST_MUL,
    ST_DIV2,
    ST_FINISH
  } state_t;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t                state_r;
  logic [CLOCK_W-1:0]    clock_hz_r;
  logic [PERIOD_W-1:0]   stored_period_r;

  // divider registers
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      quo_r;
  logic [DIV_W-1:0]      dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;

  // request payload and working values
  logic [CHAN_W-1:0]     chan_r;
  logic [MATCH_W-1:0]    match_r;
  logic [DIV_W-1:0]      count_r;
  logic [PRESC_W-1:0]    ps_r;
  logic                  err_r;

  // output register
  logic                  out_valid_r;
  logic [PERIOD_W-1:0]   out_period_r;
  logic [PRESC_W-1:0]    out_prescale_r;
  logic [MATCH_W-1:0]    out_match_r;
  logic [CHAN_W-1:0]     out_chan_r;
  logic                  out_err_r;

  logic                  in_take;
  logic                  out_free;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W+1:0]      diff;
  logic                  ge;
  logic [DIV_W-1:0]      rem_nxt;
  logic [DIV_W-1:0]      quo_nxt;
  logic [DIV_W-1:0]      product;

  // one restoring division step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = ~diff[DIV_W+1];
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  assign product  = {{(DIV_W-MATCH_W){1'b0}}, match_r} *
                    {{(DIV_W-PERIOD_W){1'b0}}, count_r[PERIOD_W-1:0]};
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      clock_hz_r      <= CLOCK_HZ_RESET;
      stored_period_r <= PERIOD_MAX;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_clock_hz;
      end
      // drop the result once taken, unless the next one is posted now
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            chan_r  <= in_target_channel;
            match_r <= in_current_match;
            rem_r   <= '0;
            quo_r   <= DIV_W'(clock_hz_r);
            dvs_r   <= in_wanted_freq;
            cnt_r   <= '0;
            ps_r    <= '0;
            err_r   <= (in_wanted_freq == '0) || (stored_period_r == '0);
            if ((in_wanted_freq == '0) || (stored_period_r == '0)) begin
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            // count wraps to all ones when the quotient is zero
            count_r <= quo_nxt - 1'b1;
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          // halve until the count fits the period width, saturate past max
          if (count_r[DIV_W-1:PERIOD_W] != '0) begin
            if (ps_r == PRESCALE_MAX) begin
              count_r <= DIV_W'(PERIOD_MAX);
              state_r <= ST_MUL;
            end else begin
              count_r <= count_r >> 1;
              ps_r    <= ps_r + 1'b1;
            end
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem_r   <= '0;
          quo_r   <= product;
          dvs_r   <= DIV_W'(stored_period_r);
          cnt_r   <= '0;
          state_r <= ST_DIV2;
        end
        ST_DIV2: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // post the result once the output register is free
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_chan_r     <= chan_r;
            out_err_r      <= err_r;
            out_period_r   <= err_r ? '0 : count_r[PERIOD_W-1:0];
            out_prescale_r <= err_r ? '0 : ps_r;
            out_match_r    <= err_r ? '0 : quo_r[MATCH_W-1:0];
            if (!err_r) begin
              stored_period_r <= count_r[PERIOD_W-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_new_period    = out_period_r;
  assign out_new_prescale  = out_prescale_r;
  assign out_new_match     = out_match_r;
  assign out_match_channel = out_chan_r;
  assign out_error_flag    = out_err_r;

  `ASSERT_NEXT(a_take_starts_work, clk, rst_n, in_valid && !in_stall, state_r != ST_IDLE)
  `ASSERT_IMPLY(a_err_zero_payload, clk, rst_n, out_valid_r && out_err_r, (out_period_r == '0) && (out_prescale_r == '0) && (out_match_r == '0))
  `ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_FINISH))
  `ASSERT_IMPLY(a_period_update, clk, rst_n, $past(rst_n) && !$stable(stored_period_r), $past(state_r == ST_FINISH) && $past(!err_r))
  `ASSERT_IMPLY(a_norm_fits, clk, rst_n, state_r == ST_MUL, count_r[DIV_W-1:PERIOD_W] == '0)

endmodule
